/* hdl/tsc_pkg.sv */
// Shared types and constants of the thermostat setpoint controller.
// Used by tsc_front, tsc_queue, tsc_back and thermostat_setpoint_controller.
// Depends on nothing.
package tsc_pkg;

  typedef enum logic [1:0] {
    REQ_ENC      = 2'd0,
    REQ_SEL_LOW  = 2'd1,
    REQ_SEL_HIGH = 2'd2,
    REQ_TEMP     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HEAT = 2'd1,
    MODE_COOL = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SRC_TEMP  = 2'd0,
    SRC_LOW   = 2'd1,
    SRC_HIGH  = 2'd2,
    SRC_SPARE = 2'd3
  } servo_src_e;

  localparam int F16W       = 13;
  localparam int WholeW     = 9;
  localparam int CountW     = 6;
  localparam int SetpointW  = 7;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CountW-1:0]    CountMax     = 6'd40;
  localparam logic [SetpointW-1:0] SetpointBase = 7'd50;
  localparam logic [WholeW:0]      AlarmMargin  = 10'd3;
  localparam logic [7:0]           ServoOffset  = 8'd52;
  localparam logic [F16W-1:0]      F16Offset    = 13'd512;
  // Reciprocals: x/5 = (x*52429)>>18 for 16-bit x, n/5 = (n*205)>>10 for 10-bit n
  localparam logic [15:0]          RecipFive16  = 16'd52429;
  localparam logic [7:0]           RecipFive10  = 8'd205;

  // One classified event as it sits in the queue
  typedef struct packed {
    req_e            kind;
    logic            enc_a;
    logic            enc_b;
    logic [F16W-1:0] f16;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* hdl/tsc_front.sv */
// Front end: classifies an incoming event and converts a raw Celsius
// reading to sixteenths of a degree Fahrenheit. Uses tsc_pkg.
module tsc_front (
  input  logic [1:0]          req_type_i,
  input  logic                enc_a_i,
  input  logic                enc_b_i,
  input  logic [10:0]         raw_temp_i,
  output tsc_pkg::item_t      item_o
);

  logic [14:0]              raw9;
  logic [30:0]              prod;
  logic [tsc_pkg::F16W-1:0] quot;

  // raw*9/5 + 512, the divide done with a reciprocal multiply
  assign raw9 = {1'b0, raw_temp_i, 3'b000} + {4'b0000, raw_temp_i};
  assign prod = 31'(raw9) * 31'(tsc_pkg::RecipFive16);
  assign quot = prod[30:18];

  always_comb begin
    item_o.kind  = tsc_pkg::req_e'(req_type_i);
    item_o.enc_a = enc_a_i;
    item_o.enc_b = enc_b_i;
    item_o.f16   = quot + tsc_pkg::F16Offset;
  end

endmodule

/* hdl/tsc_queue.sv */
// Short FIFO between front and back ends, so each side stalls on its own.
// Holds tsc_pkg::item_t entries; uses tsc_pkg.
module tsc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tsc_pkg::item_t   push_item_i,
  input  logic             pop_i,
  output tsc_pkg::item_t   head_o,
  output tsc_pkg::q_stat_t stat_o
);

  tsc_pkg::item_t                   mem_q [tsc_pkg::QueueDepth];
  logic [tsc_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tsc_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tsc_pkg::QueueCntW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == tsc_pkg::QueuePtrW'(tsc_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == tsc_pkg::QueuePtrW'(tsc_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == tsc_pkg::QueueCntW'(tsc_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

/* hdl/tsc_back.sv */
// Back end: quadrature decoder, setpoint counts, alarm, servo duty and the
// output register of the result channel. Uses tsc_pkg.
module tsc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  tsc_pkg::item_t       item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           climate_mode_o,
  output logic                 alarm_pulse_o,
  output logic [7:0]           servo_duty_o,
  output logic [8:0]           temp_whole_o,
  output logic [3:0]           temp_tenths_o,
  output logic [6:0]           low_setpoint_o,
  output logic [6:0]           high_setpoint_o,
  output logic                 setpoint_changed_o
);

  logic [1:0]                    phase_q, phase_d;
  logic [tsc_pkg::CountW-1:0]    low_q, low_d, high_q, high_d;
  logic                          edit_high_q, edit_high_d;
  tsc_pkg::servo_src_e           src_q, src_d;
  logic                          armed_q, armed_d;
  logic [tsc_pkg::F16W-1:0]      f16_q, f16_d;
  logic                          out_valid_q, out_valid_d;

  logic [1:0]                    next_phase;
  logic                          up, dn, changed;
  logic [tsc_pkg::CountW-1:0]    cnt_sel, cnt_new;
  logic [tsc_pkg::WholeW-1:0]    whole;
  logic [7:0]                    tenths_prod;
  logic [tsc_pkg::SetpointW-1:0] lo, hi;
  logic [tsc_pkg::WholeW:0]      whole_x, lo_x, hi_x;
  logic                          armed_mid, fire;
  tsc_pkg::mode_e                mode;
  logic [tsc_pkg::WholeW-1:0]    servo_x;
  logic [17:0]                   servo_prod;
  logic [7:0]                    duty;

  assign pop_o = item_valid_i && (!out_valid_q || !out_stall_i);

  // Gray-code decoder: one channel tested first per phase
  always_comb begin
    next_phase = phase_q;
    up = 1'b0;
    dn = 1'b0;
    unique case (phase_q)
      2'd0: begin
        if (item_i.enc_a) begin
          next_phase = 2'd1; dn = 1'b1;
        end else if (item_i.enc_b) begin
          next_phase = 2'd3; up = 1'b1;
        end
      end
      2'd1: begin
        if (item_i.enc_b) begin
          next_phase = 2'd2; dn = 1'b1;
        end else if (!item_i.enc_a) begin
          next_phase = 2'd0; up = 1'b1;
        end
      end
      2'd2: begin
        if (!item_i.enc_a) begin
          next_phase = 2'd3; dn = 1'b1;
        end else if (!item_i.enc_b) begin
          next_phase = 2'd1; up = 1'b1;
        end
      end
      default: begin
        if (!item_i.enc_b) begin
          next_phase = 2'd0; dn = 1'b1;
        end else if (item_i.enc_a) begin
          next_phase = 2'd2; up = 1'b1;
        end
      end
    endcase
  end

  // Saturating step of the setpoint being edited
  always_comb begin
    cnt_sel = edit_high_q ? high_q : low_q;
    cnt_new = cnt_sel;
    if (up && cnt_sel < tsc_pkg::CountMax) begin
      cnt_new = cnt_sel + 1'b1;
    end else if (dn && cnt_sel != '0) begin
      cnt_new = cnt_sel - 1'b1;
    end
  end

  // Next state for the event at the queue head
  always_comb begin
    phase_d     = phase_q;
    low_d       = low_q;
    high_d      = high_q;
    edit_high_d = edit_high_q;
    src_d       = src_q;
    f16_d       = f16_q;
    changed     = 1'b0;
    unique case (item_i.kind)
      tsc_pkg::REQ_ENC: begin
        phase_d = next_phase;
        changed = (next_phase != phase_q);
        if (edit_high_q) begin
          high_d = cnt_new;
        end else begin
          low_d = cnt_new;
        end
      end
      tsc_pkg::REQ_SEL_LOW: begin
        edit_high_d = 1'b0;
        src_d       = tsc_pkg::SRC_LOW;
      end
      tsc_pkg::REQ_SEL_HIGH: begin
        edit_high_d = 1'b1;
        src_d       = tsc_pkg::SRC_HIGH;
      end
      default: begin
        f16_d = item_i.f16;
      end
    endcase
  end

  // Result from the updated state
  always_comb begin
    whole       = f16_d[tsc_pkg::F16W-1:4];
    tenths_prod = {4'b0000, f16_d[3:0]} * 8'd10;
    lo          = tsc_pkg::SetpointBase + {1'b0, low_d};
    hi          = tsc_pkg::SetpointBase + {1'b0, high_d};
    whole_x     = {1'b0, whole};
    lo_x        = {3'b000, lo};
    hi_x        = {3'b000, hi};

    if (whole_x < lo_x) begin
      mode = tsc_pkg::MODE_HEAT;
    end else if (whole_x > hi_x) begin
      mode = tsc_pkg::MODE_COOL;
    end else begin
      mode = tsc_pkg::MODE_IDLE;
    end

    // Arm inside the widened band, fire once on leaving it
    armed_mid = armed_q || ((whole_x + tsc_pkg::AlarmMargin > lo_x) &&
                            (whole_x < hi_x + tsc_pkg::AlarmMargin));
    fire      = armed_mid && ((whole_x + tsc_pkg::AlarmMargin < lo_x) ||
                              (whole_x > hi_x + tsc_pkg::AlarmMargin));
    armed_d   = armed_mid && !fire;

    case (src_d)
      tsc_pkg::SRC_TEMP: servo_x = whole;
      tsc_pkg::SRC_LOW:  servo_x = {2'b00, lo};
      default:           servo_x = {2'b00, hi};
    endcase
    // 24x/60 = 2x/5
    servo_prod = {servo_x, 1'b0} * 18'(tsc_pkg::RecipFive10);
    duty       = tsc_pkg::ServoOffset - servo_prod[17:10];
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      low_q       <= '0;
      high_q      <= '0;
      edit_high_q <= 1'b1;
      src_q       <= tsc_pkg::SRC_TEMP;
      armed_q     <= 1'b0;
      f16_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q     <= phase_d;
        low_q       <= low_d;
        high_q      <= high_d;
        edit_high_q <= edit_high_d;
        src_q       <= src_d;
        armed_q     <= armed_d;
        f16_q       <= f16_d;
      end
    end
  end

  // Result payload, loaded with each transaction taken from the queue
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      climate_mode_o     <= mode;
      alarm_pulse_o      <= fire;
      servo_duty_o       <= duty;
      temp_whole_o       <= whole;
      temp_tenths_o      <= tenths_prod[7:4];
      low_setpoint_o     <= lo;
      high_setpoint_o    <= hi;
      setpoint_changed_o <= changed;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/thermostat_setpoint_controller.sv */
// Thermostat setpoint controller, top level.
// Input channel: in_valid_i / in_stall_o carry one event per transaction
// (encoder sample, select low, select high, or raw temperature reading).
// Output channel: out_valid_o / out_stall_i carry one result per event:
// climate mode, alarm pulse, servo duty, temperature and both setpoints.
// An accepted transaction passes through one register in the two-entry queue
// and one in the output stage before its result is valid.
// Throughput: one transaction per cycle while out_stall_i does not hold a pending
// result; the back end updates its state as it takes each event, so each event sees all earlier ones.
// in_stall_o rises only when the two-entry queue is full; with a steady input
// stream one held item already sits in the queue, so one more item pushed while
// out_stall_i holds a pending result fills it (two items from empty).
// The pending result holds steady while out_stall_i is high.
// Reset (rst_ni low, asynchronous) empties the queue and output stage and
// returns the decoder to phase zero, both counts to zero (50 F), editing to
// the high setpoint, the servo to follow temperature, the alarm to disarmed
// and the stored temperature to zero.
// Depends on tsc_pkg, tsc_front, tsc_queue and tsc_back.
module thermostat_setpoint_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic        enc_a_i,
  input  logic        enc_b_i,
  input  logic [10:0] raw_temp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  climate_mode_o,
  output logic        alarm_pulse_o,
  output logic [7:0]  servo_duty_o,
  output logic [8:0]  temp_whole_o,
  output logic [3:0]  temp_tenths_o,
  output logic [6:0]  low_setpoint_o,
  output logic [6:0]  high_setpoint_o,
  output logic        setpoint_changed_o
);

  tsc_pkg::item_t   front_item;
  tsc_pkg::item_t   head_item;
  tsc_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  assign in_stall_o = q_stat.full;
  assign push       = in_valid_i && !q_stat.full;

  tsc_front u_front (
    .req_type_i (req_type_i),
    .enc_a_i    (enc_a_i),
    .enc_b_i    (enc_b_i),
    .raw_temp_i (raw_temp_i),
    .item_o     (front_item)
  );

  tsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .stat_o      (q_stat)
  );

  tsc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_valid_i       (!q_stat.empty),
    .item_i             (head_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .climate_mode_o     (climate_mode_o),
    .alarm_pulse_o      (alarm_pulse_o),
    .servo_duty_o       (servo_duty_o),
    .temp_whole_o       (temp_whole_o),
    .temp_tenths_o      (temp_tenths_o),
    .low_setpoint_o     (low_setpoint_o),
    .high_setpoint_o    (high_setpoint_o),
    .setpoint_changed_o (setpoint_changed_o)
  );

  // Queue status is never full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Saturating counts keep both setpoints within 50..90
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (low_setpoint_o >= 7'd50 && low_setpoint_o <= 7'd90 &&
                     high_setpoint_o >= 7'd50 && high_setpoint_o <= 7'd90))
    else $error("setpoint out of range");

  // The alarm fires only outside the band, so heat or cool must be on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alarm_pulse_o) |->
      (climate_mode_o == tsc_pkg::MODE_HEAT || climate_mode_o == tsc_pkg::MODE_COOL))
    else $error("alarm pulse with idle climate mode");

  // No result appears without a queued transaction the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_stat.empty))
    else $error("result produced from an empty queue");

endmodule
